// ===== rtl/ucd_pkg.sv =====
// Package for the undirected cycle detector.
// Holds the controller state type, the command and status structs, and the fixed field widths.
// No dependencies.
package ucd_pkg;

   localparam int unsigned MaxVertices = 1024;
   localparam int unsigned MaxEdges    = 1024;
   localparam int unsigned NodeWidth   = 10;
   localparam int unsigned CountWidth  = 11;
   localparam logic [CountWidth-1:0] CountReset = 11'd1024;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_CHK,
      ST_INIT,
      ST_EDGE,
      ST_EDGE_LD,
      ST_FIND_A_RD,
      ST_FIND_A_CHK,
      ST_FIND_B_RD,
      ST_FIND_B_CHK,
      ST_LINK_A,
      ST_LINK_B,
      ST_SWEEP,
      ST_SWEEP_CHK,
      ST_REPORT
   } ucd_state_type;

   typedef struct packed {
      logic take_req;
      logic idx_inc;
      logic scan_rd;
      logic store_edge;
      logic set_ovf;
      logic init_wr;
      logic vcnt_inc;
      logic vcnt_clr;
      logic edge_rd;
      logic cur_from_a;
      logic cur_from_b;
      logic node_rd;
      logic cur_step;
      logic save_ra;
      logic save_rb;
      logic link_a;
      logic link_b;
      logic sweep_rd;
      logic found_chk;
      logic load_rsp;
      logic clear_run;
   } ucd_cmd_type;

   typedef struct packed {
      logic req_op;
      logic req_bad;
      logic scan_done;
      logic scan_hit;
      logic store_full;
      logic vcnt_last;
      logic at_root;
      logic same_root;
      logic rsp_free;
   } ucd_status_type;

endpackage

// ===== rtl/ucd_ctrl.sv =====
// Controller state machine of the undirected cycle detector.
// Sequences edge lookup, store, union-find merge and root sweep; depends on ucd_pkg.
module ucd_ctrl
   import ucd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  ucd_status_type status,
   output ucd_cmd_type    cmd
);

   ucd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take_req = 1'b1;
               if (status.req_op) begin
                  state_in = ST_INIT;
               end else if (!status.req_bad) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               if (status.store_full) begin
                  cmd.set_ovf = 1'b1;
               end else begin
                  cmd.store_edge = 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (status.scan_hit) begin
               state_in = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (status.vcnt_last) begin
               cmd.vcnt_clr = 1'b1;
               state_in     = ST_EDGE;
            end else begin
               cmd.vcnt_inc = 1'b1;
            end
         end
         ST_EDGE: begin
            if (status.scan_done) begin
               state_in = ST_SWEEP;
            end else begin
               cmd.edge_rd = 1'b1;
               state_in    = ST_EDGE_LD;
            end
         end
         ST_EDGE_LD: begin
            cmd.cur_from_a = 1'b1;
            state_in       = ST_FIND_A_RD;
         end
         ST_FIND_A_RD: begin
            cmd.node_rd = 1'b1;
            state_in    = ST_FIND_A_CHK;
         end
         ST_FIND_A_CHK: begin
            if (status.at_root) begin
               cmd.save_ra    = 1'b1;
               cmd.cur_from_b = 1'b1;
               state_in       = ST_FIND_B_RD;
            end else begin
               cmd.cur_step = 1'b1;
               state_in     = ST_FIND_A_RD;
            end
         end
         ST_FIND_B_RD: begin
            cmd.node_rd = 1'b1;
            state_in    = ST_FIND_B_CHK;
         end
         ST_FIND_B_CHK: begin
            if (status.at_root) begin
               cmd.save_rb = 1'b1;
               state_in    = ST_LINK_A;
            end else begin
               cmd.cur_step = 1'b1;
               state_in     = ST_FIND_B_RD;
            end
         end
         ST_LINK_A: begin
            cmd.link_a = 1'b1;
            if (status.same_root) begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_EDGE;
            end else begin
               state_in = ST_LINK_B;
            end
         end
         ST_LINK_B: begin
            cmd.link_b  = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = ST_EDGE;
         end
         ST_SWEEP: begin
            cmd.sweep_rd = 1'b1;
            state_in     = ST_SWEEP_CHK;
         end
         ST_SWEEP_CHK: begin
            cmd.found_chk = 1'b1;
            if (status.vcnt_last) begin
               state_in = ST_REPORT;
            end else begin
               cmd.vcnt_inc = 1'b1;
               state_in     = ST_SWEEP;
            end
         end
         ST_REPORT: begin
            if (status.rsp_free) begin
               cmd.load_rsp  = 1'b1;
               cmd.clear_run = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/ucd_dp.sv =====
// Datapath of the undirected cycle detector: edge store, union-find node memory,
// counters, vertex count register and result register; depends on ucd_pkg.
module ucd_dp
   import ucd_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = MaxVertices,
   parameter int unsigned MAX_EDGES    = MaxEdges
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ucd_cmd_type           cmd,
   output ucd_status_type        status,
   input  logic                  req_opcode,
   input  logic [NodeWidth-1:0]  req_node_a,
   input  logic [NodeWidth-1:0]  req_node_b,
   input  logic                  csr_write,
   input  logic [CountWidth-1:0] csr_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_has_cycle,
   output logic                  rsp_edges_dropped
);

   localparam int unsigned VW  = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
   localparam int unsigned EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned TW  = $clog2(MAX_EDGES + 1);
   localparam int unsigned NW  = 2 * VW + 1;
   localparam int unsigned EDW = 2 * NodeWidth;

   logic [EDW-1:0] edge_mem [MAX_EDGES];
   logic [NW-1:0]  node_mem [MAX_VERTICES];

   logic [NodeWidth-1:0]  a_ff, b_ff;
   logic [TW-1:0]         idx_ff, total_ff;
   logic                  ovf_ff;
   logic [VW-1:0]         vcnt_ff, cur_ff;
   logic [EDW-1:0]        edge_q_ff;
   logic [NW-1:0]         node_q_ff, ra_ff, rb_ff;
   logic                  found_ff;
   logic [CountWidth-1:0] count_ff;
   logic                  rsp_valid_ff, rsp_cycle_ff, rsp_drop_ff;

   logic [VW-1:0]  q_par, q_min, ra_par, ra_min, rb_par, rb_min, edge_a_v, edge_b_v, min_ab;
   logic           q_cyc, ra_cyc, rb_cyc;
   logic           wr_en;
   logic [VW-1:0]  wr_addr;
   logic [NW-1:0]  wr_data;

   assign q_par   = node_q_ff[VW-1:0];
   assign q_min   = node_q_ff[2*VW-1:VW];
   assign q_cyc   = node_q_ff[NW-1];
   assign ra_par  = ra_ff[VW-1:0];
   assign ra_min  = ra_ff[2*VW-1:VW];
   assign ra_cyc  = ra_ff[NW-1];
   assign rb_par  = rb_ff[VW-1:0];
   assign rb_min  = rb_ff[2*VW-1:VW];
   assign rb_cyc  = rb_ff[NW-1];
   assign edge_a_v = VW'(edge_q_ff[NodeWidth-1:0]);
   assign edge_b_v = VW'(edge_q_ff[EDW-1:NodeWidth]);
   assign min_ab   = (ra_min < rb_min) ? ra_min : rb_min;

   assign status.req_op     = req_opcode;
   assign status.req_bad    = (32'(req_node_a) >= MAX_VERTICES) ||
                              (32'(req_node_b) >= MAX_VERTICES);
   assign status.scan_done  = (idx_ff == total_ff);
   assign status.scan_hit   = (edge_q_ff == {b_ff, a_ff}) || (edge_q_ff == {a_ff, b_ff});
   assign status.store_full = (32'(total_ff) >= MAX_EDGES);
   assign status.vcnt_last  = (32'(vcnt_ff) == MAX_VERTICES - 1);
   assign status.at_root    = (q_par == cur_ff);
   assign status.same_root  = (ra_par == rb_par);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = vcnt_ff;
      wr_data = {1'b0, vcnt_ff, vcnt_ff};
      if (cmd.init_wr) begin
         wr_en = 1'b1;
      end else if (cmd.link_a) begin
         wr_en   = 1'b1;
         wr_addr = ra_par;
         wr_data = (ra_par == rb_par) ? {1'b1, ra_min, ra_par} : {ra_cyc, ra_min, rb_par};
      end else if (cmd.link_b) begin
         wr_en   = 1'b1;
         wr_addr = rb_par;
         wr_data = {ra_cyc | rb_cyc, min_ab, rb_par};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      if (cmd.node_rd) begin
         node_q_ff <= node_mem[cur_ff];
      end else if (cmd.sweep_rd) begin
         node_q_ff <= node_mem[vcnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_edge) begin
         edge_mem[total_ff[EW-1:0]] <= {b_ff, a_ff};
      end
      if (cmd.scan_rd || cmd.edge_rd) begin
         edge_q_ff <= edge_mem[idx_ff[EW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         a_ff <= req_node_a;
         b_ff <= req_node_b;
      end
      if (cmd.cur_from_a) begin
         cur_ff <= edge_a_v;
      end else if (cmd.cur_from_b) begin
         cur_ff <= edge_b_v;
      end else if (cmd.cur_step) begin
         cur_ff <= q_par;
      end
      if (cmd.save_ra) begin
         ra_ff <= node_q_ff;
      end
      if (cmd.save_rb) begin
         rb_ff <= node_q_ff;
      end
      if (cmd.take_req) begin
         idx_ff  <= '0;
         vcnt_ff <= '0;
      end else begin
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.vcnt_clr) begin
            vcnt_ff <= '0;
         end else if (cmd.vcnt_inc) begin
            vcnt_ff <= vcnt_ff + 1'b1;
         end
      end
      if (cmd.take_req) begin
         found_ff <= 1'b0;
      end else if (cmd.found_chk && (q_par == vcnt_ff) && q_cyc &&
                   (32'(q_min) < 32'(count_ff))) begin
         found_ff <= 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_cycle_ff <= found_ff;
         rsp_drop_ff  <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         count_ff     <= CountReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            count_ff <= csr_value;
         end
         if (cmd.clear_run) begin
            total_ff <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            if (cmd.store_edge) begin
               total_ff <= total_ff + 1'b1;
            end
            if (cmd.set_ovf) begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_has_cycle     = rsp_cycle_ff;
   assign rsp_edges_dropped = rsp_drop_ff;

endmodule

// ===== rtl/undirected_cycle_detect.sv =====
// Top level of the undirected cycle detector.
// Joins the controller ucd_ctrl and the datapath ucd_dp; depends on ucd_pkg.
// Usage:
//   req_ channel carries one transaction per item: opcode 0 adds an undirected
//   edge (node_a, node_b), opcode 1 runs detection, reports and clears the graph.
//   rsp_ channel returns one transaction per run: has_cycle and edges_dropped.
//   csr_ channel writes vertex_count (walks consider labels below it).
// Operation:
//   Edge item: a compare per stored edge against the single-port edge memory;
//   duplicates end early.
//   Run item: initialize the node memory, then per edge a union-find walk of
//   the root paths of both ends and a link (LINK_B is skipped when both ends
//   share a root), then close the edge list, sweep roots and load the result.
//   One item is in work at a time; req_tready is high only between items.
// Reset clears the edge count, overflow flag, result valid flag and state; the
// node memory is rewritten at the start of every run.
// When the receiver stalls, the result is held in the output register; the block
// takes further edge items, and a following run waits before reporting.
module undirected_cycle_detect
   import ucd_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = MaxVertices,
   parameter int unsigned MAX_EDGES    = MaxEdges
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,  // opcode[0], node_a[10:1], node_b[20:11], zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // has_cycle[0], edges_dropped[1], zero
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CountWidth-1:0] csr_data    // vertex_count
);

   ucd_cmd_type    cmd;
   ucd_status_type status;
   logic           has_cycle, edges_dropped;

   assign csr_ready = 1'b1;

   ucd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ucd_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_tdata[0]),
      .req_node_a        (req_tdata[10:1]),
      .req_node_b        (req_tdata[20:11]),
      .csr_write         (csr_valid && csr_ready),
      .csr_value         (csr_data),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_has_cycle     (has_cycle),
      .rsp_edges_dropped (edges_dropped)
   );

   assign rsp_tdata = {6'b0, edges_dropped, has_cycle};

endmodule

// ===== rtl/ucd_check.sv =====
// Port checker for the undirected cycle detector, bound to undirected_cycle_detect.
// Depends on the top level's ports only.
module ucd_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result transaction changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[0] |=> !req_tready && !$rose(rsp_tvalid))
      else $error("run transaction did not occupy the block");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:2] == 6'b0)
      else $error("result padding not zero");

endmodule

bind undirected_cycle_detect ucd_check u_ucd_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/undirected_cycle_detect_tb.sv =====
// Testbench for undirected_cycle_detect: drives edge and run transactions and
// vertex_count writes, predicts has_cycle and edges_dropped with a union-find model.
// Depends on ucd_pkg and the RTL of undirected_cycle_detect.
`timescale 1ns / 1ps

module undirected_cycle_detect_tb
   import ucd_pkg::*;
();

   localparam logic OpEdge = 1'b0;
   localparam logic OpRun  = 1'b1;

   typedef struct packed {
      logic has_cycle;
      logic edges_dropped;
   } verdict_type;

   class cycle_scoreboard;
      logic [CountWidth-1:0] vertex_count;
      logic [NodeWidth-1:0]  end_a[MaxEdges];
      logic [NodeWidth-1:0]  end_b[MaxEdges];
      int unsigned           edge_total;
      bit                    overflow_seen;
      verdict_type           pending[$];
      int                    errors;

      function new();
         vertex_count  = CountReset;
         edge_total    = 0;
         overflow_seen = 0;
         errors        = 0;
      endfunction

      function int unsigned root_of(ref int unsigned grp[MaxVertices], input int unsigned v);
         while (grp[v] != v) v = grp[v];
         return v;
      endfunction

      function bit find_cycle();
         int unsigned grp[MaxVertices];
         bit          cyc[MaxVertices];
         int unsigned ra, rb, lim;
         for (int v = 0; v < MaxVertices; v++) begin
            grp[v] = v;
            cyc[v] = 0;
         end
         for (int i = 0; i < edge_total; i++) begin
            ra = root_of(grp, end_a[i]);
            rb = root_of(grp, end_b[i]);
            if (ra == rb) begin
               cyc[ra] = 1;
            end else begin
               grp[ra] = rb;
               cyc[rb] = cyc[rb] | cyc[ra];
            end
         end
         lim = (vertex_count < MaxVertices) ? vertex_count : MaxVertices;
         for (int v = 0; v < lim; v++)
            if (cyc[root_of(grp, v)]) return 1;
         return 0;
      endfunction

      function void note_request(logic op, logic [NodeWidth-1:0] a, logic [NodeWidth-1:0] b);
         verdict_type vd;
         if (op == OpEdge) begin
            for (int i = 0; i < edge_total; i++)
               if ((end_a[i] == a && end_b[i] == b) || (end_a[i] == b && end_b[i] == a))
                  return;
            if (edge_total >= MaxEdges) begin
               overflow_seen = 1;
            end else begin
               end_a[edge_total] = a;
               end_b[edge_total] = b;
               edge_total++;
            end
         end else begin
            vd.has_cycle     = find_cycle();
            vd.edges_dropped = overflow_seen;
            pending = {pending, vd};
            edge_total    = 0;
            overflow_seen = 0;
         end
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(logic [7:0] data);
         verdict_type exp_vd;
         if (pending.size() == 0) begin
            report($sformatf("unexpected response %h", data));
            return;
         end
         exp_vd = pending.pop_front();
         if (data[0] !== exp_vd.has_cycle)
            report($sformatf("has_cycle %b, want %b", data[0], exp_vd.has_cycle));
         if (data[1] !== exp_vd.edges_dropped)
            report($sformatf("edges_dropped %b, want %b", data[1], exp_vd.edges_dropped));
         if (data[7:2] !== '0)
            report($sformatf("padding bits %h", data[7:2]));
      endtask
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [7:0]            rsp_tdata;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CountWidth-1:0] csr_data = '0;

   int unsigned     send_idle_pct = 0;
   int unsigned     recv_idle_pct = 0;
   cycle_scoreboard board = new();

   always #6 clock = ~clock;

   undirected_cycle_detect i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   task automatic send_item(logic op, int unsigned a, int unsigned b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {3'b0, NodeWidth'(b), NodeWidth'(a), op};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, NodeWidth'(a), NodeWidth'(b));
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   task automatic write_count(int unsigned val);
      drain();
      repeat (3 * MaxVertices + 8 * MaxEdges) @(negedge clock);
      csr_valid <= 1;
      csr_data  <= CountWidth'(val);
      do @(posedge clock); while (!csr_ready);
      board.vertex_count = CountWidth'(val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic random_graph(int unsigned n_edges, int unsigned span);
      int unsigned a;
      for (int i = 0; i < n_edges; i++) begin
         a = $urandom_range(span);
         case ($urandom_range(9))
            0: send_item(OpEdge, a, a);
            1: send_item(OpEdge, $urandom, $urandom);
            default: send_item(OpEdge, a, $urandom_range(span));
         endcase
      end
      send_item(OpRun, $urandom, $urandom);
   endtask

   initial begin
      #200_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty, path, triangle, self-loop, repeated edge, extremes, vertex_count limits
      send_item(OpRun, 10'h3FF, 10'h3FF);
      send_item(OpEdge, 0, 1);
      send_item(OpEdge, 1, 2);
      send_item(OpRun, 0, 0);
      send_item(OpEdge, 0, 1);
      send_item(OpEdge, 1, 2);
      send_item(OpEdge, 2, 0);
      send_item(OpRun, 0, 0);
      send_item(OpEdge, 1023, 1023);
      send_item(OpRun, 0, 0);
      send_item(OpEdge, 5, 6);
      send_item(OpEdge, 6, 5);
      send_item(OpEdge, 5, 6);
      send_item(OpRun, 0, 0);
      send_item(OpEdge, 1023, 0);
      send_item(OpEdge, 0, 512);
      send_item(OpEdge, 512, 1023);
      send_item(OpRun, 0, 0);
      write_count(0);
      send_item(OpEdge, 3, 3);
      send_item(OpRun, 0, 0);
      write_count(11'h7FF);
      send_item(OpEdge, 1023, 1023);
      send_item(OpRun, 0, 0);
      write_count(4);
      send_item(OpEdge, 10, 10);
      send_item(OpEdge, 1, 2);
      send_item(OpRun, 0, 0);

      // overflow: fill the store with distinct edges plus extras
      write_count(1024);
      for (int i = 0; i < MaxEdges + 3; i++)
         send_item(OpEdge, i % 1024, (i + 1 + i / 1024) % 1024);
      send_item(OpRun, 0, 0);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 73 : 0;
         recv_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 16 : 0;
         write_count((ph == 0) ? 1 : (ph == 1) ? 700 : 1024);
         for (int g = 0; g < 25; g++) begin
            random_graph($urandom_range(1, 7), (g % 3 == 0) ? 15 : 1023);
            if (g == 10) drain();
            if (g % 8 == 7) write_count($urandom_range(1, 1024));
         end
      end

      drain();
      repeat (3 * MaxVertices + 8 * MaxEdges) @(negedge clock);
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
